### hw/rtl/bsdt_pkg.sv
// Shared types, codes and constants for the beacon score device table.
`timescale 1ns / 1ps
package bsdt_pkg;

  localparam int TABLE_ENTRIES_DEF = 24;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [15:0]       TARGET_MFR   = 16'h09C8;
  localparam logic signed [7:0] NEAR_DBM     = -8'sd50;
  localparam logic [6:0]        SCORE_CAP    = 7'd100;
  localparam logic [32:0]       RECENT_EXTRA = 33'd2000;

  localparam logic [6:0]        RST_MFR_WEIGHT    = 7'd80;
  localparam logic [6:0]        RST_NAME_WEIGHT   = 7'd30;
  localparam logic [6:0]        RST_UUID_WEIGHT   = 7'd15;
  localparam logic [6:0]        RST_PROX_BONUS    = 7'd10;
  localparam logic [6:0]        RST_LIKELY        = 7'd70;
  localparam logic [6:0]        RST_POSSIBLE      = 7'd40;
  localparam logic signed [7:0] RST_RSSI_FLOOR    = -8'sd90;
  localparam logic [31:0]       RST_HB_PERIOD     = 32'd10000;

  typedef enum logic {
    OP_ADV       = 1'b0,
    OP_HEARTBEAT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    METHOD_NONE = 2'd0,
    METHOD_MFR  = 2'd1,
    METHOD_NAME = 2'd2,
    METHOD_UUID = 2'd3
  } method_e;

  typedef enum logic [1:0] {
    VERDICT_CANDIDATE = 2'd0,
    VERDICT_POSSIBLE  = 2'd1,
    VERDICT_LIKELY    = 2'd2
  } verdict_e;

  typedef enum logic [2:0] {
    REG_MFR_WEIGHT   = 3'd0,
    REG_NAME_WEIGHT  = 3'd1,
    REG_UUID_WEIGHT  = 3'd2,
    REG_PROX_BONUS   = 3'd3,
    REG_LIKELY       = 3'd4,
    REG_POSSIBLE     = 3'd5,
    REG_RSSI_FLOOR   = 3'd6,
    REG_HB_PERIOD    = 3'd7
  } reg_index_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } back_state_e;

  typedef struct packed {
    logic [6:0]        mfr_weight;
    logic [6:0]        name_weight;
    logic [6:0]        uuid_weight;
    logic [6:0]        proximity_bonus;
    logic [6:0]        likely_level;
    logic [6:0]        possible_level;
    logic signed [7:0] rssi_floor;
    logic [31:0]       heartbeat_period_ms;
  } cfg_t;

  typedef struct packed {
    op_e        kind;
    logic [47:0] mac;
    logic [31:0] now;
    logic [6:0]  score;
    method_e     method;
    verdict_e    verdict;
  } job_t;

endpackage

### hw/rtl/bsdt_front.sv
// Front end: scores advertisements, checks heartbeat timing, forwards jobs.
`timescale 1ns / 1ps
module bsdt_front import bsdt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              push,
  input  logic              full,
  input  logic              operation,
  input  logic [47:0]       mac_address,
  input  logic signed [7:0] signal_strength,
  input  logic              has_mfr_data,
  input  logic [15:0]       mfr_id,
  input  logic              name_match,
  input  logic              uuid_match,
  input  logic [31:0]       now_ms,
  output logic              q_push,
  output job_t              q_word
);

  logic [31:0] last_heartbeat;
  logic        accept;
  logic        is_hb;
  logic        below_floor;
  logic        near;
  logic        mfr_hit;
  logic [9:0]  sum;
  logic [9:0]  total;
  logic [6:0]  score;
  logic [31:0] age;
  logic        due;
  logic        keep;
  method_e     method;
  verdict_e    verdict;

  always_comb begin
    accept      = push && !full;
    is_hb       = op_e'(operation) == OP_HEARTBEAT;
    below_floor = signal_strength < cfg.rssi_floor;
    near        = signal_strength >= NEAR_DBM;
    mfr_hit     = has_mfr_data && (mfr_id == TARGET_MFR);
    sum = (mfr_hit ? {3'b0, cfg.mfr_weight} : 10'd0)
        + (name_match ? {3'b0, cfg.name_weight} : 10'd0)
        + (uuid_match ? {3'b0, cfg.uuid_weight} : 10'd0);
    total = sum + ((sum != 10'd0 && near) ? {3'b0, cfg.proximity_bonus} : 10'd0);
    score = (total > {3'b0, SCORE_CAP}) ? SCORE_CAP : total[6:0];
    if (mfr_hit) begin
      method = METHOD_MFR;
    end else if (name_match) begin
      method = METHOD_NAME;
    end else if (uuid_match) begin
      method = METHOD_UUID;
    end else begin
      method = METHOD_NONE;
    end
    if (score >= cfg.likely_level) begin
      verdict = VERDICT_LIKELY;
    end else if (score >= cfg.possible_level) begin
      verdict = VERDICT_POSSIBLE;
    end else begin
      verdict = VERDICT_CANDIDATE;
    end
    age  = now_ms - last_heartbeat;
    due  = age >= cfg.heartbeat_period_ms;
    keep = is_hb ? due : (!below_floor && sum != 10'd0);
    q_push         = accept && keep;
    q_word.kind    = op_e'(operation);
    q_word.mac     = mac_address;
    q_word.now     = now_ms;
    q_word.score   = score;
    q_word.method  = method;
    q_word.verdict = verdict;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_heartbeat <= '0;
    end else if (accept && is_hb && due) begin
      last_heartbeat <= now_ms;
    end
  end

endmodule

### hw/rtl/bsdt_queue.sv
// Short job queue between the front end and the table engine.
`timescale 1ns / 1ps
module bsdt_queue import bsdt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic q_push,
  input  job_t q_wdata,
  output logic q_full,
  input  logic q_pop,
  output logic q_empty,
  output job_t q_rdata
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  always_comb begin
    q_full  = count == CNT_W'(QUEUE_DEPTH);
    q_empty = count == '0;
    do_push = q_push && !q_full;
    do_pop  = q_pop && !q_empty;
    q_rdata = slots[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### hw/rtl/bsdt_back.sv
// Table engine: walks the device table, allocates or updates entries, holds the result word.
`timescale 1ns / 1ps
module bsdt_back import bsdt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int IDX_W = $clog2(TABLE_ENTRIES),
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             q_empty,
  input  job_t             q_word,
  output logic             q_pop,
  output logic             empty,
  input  logic             pop,
  output logic             kind,
  output logic [IDX_W-1:0] slot_index,
  output logic             is_new,
  output logic [6:0]       confidence,
  output logic [1:0]       method,
  output logic [1:0]       verdict,
  output logic             alert
);

  logic [47:0] mac_mem  [TABLE_ENTRIES];
  logic [31:0] seen_mem [TABLE_ENTRIES];
  logic [6:0]  conf_mem [TABLE_ENTRIES];
  logic [47:0] rd_mac;
  logic [31:0] rd_seen;
  logic [6:0]  rd_conf;

  back_state_e      state;
  back_state_e      state_next;
  job_t             cur;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] issue_cnt;
  logic             chk_valid;
  logic [IDX_W-1:0] chk_idx;
  logic [31:0]      min_seen;
  logic [IDX_W-1:0] min_idx;
  logic [IDX_W-1:0] res_slot;
  logic             res_new;
  logic             res_alert;
  logic             out_valid;

  logic             is_adv;
  logic             used_full;
  logic             last_chk;
  logic [31:0]      age;
  logic [32:0]      window;
  logic             hb_hit;
  logic             found;
  logic             decide;
  logic             older;
  logic [IDX_W-1:0] min_sel;
  logic [31:0]      min_seen_sel;
  logic [IDX_W-1:0] new_slot;
  logic             issue;
  logic             mem_we;
  logic             load_out;

  always_comb begin
    is_adv       = cur.kind == OP_ADV;
    used_full    = used == CNT_W'(TABLE_ENTRIES);
    last_chk     = chk_valid && (CNT_W'(chk_idx) + 1'b1 == used);
    age          = cur.now - rd_seen;
    window       = {1'b0, cfg.heartbeat_period_ms} + RECENT_EXTRA;
    hb_hit       = (rd_conf >= cfg.likely_level) && ({1'b0, age} < window);
    found        = chk_valid && (is_adv ? (rd_mac == cur.mac) : hb_hit);
    decide       = (state == ST_SCAN) && ((used == '0) || found || last_chk);
    older        = (chk_idx == '0) || (rd_seen < min_seen);
    min_sel      = older ? chk_idx : min_idx;
    min_seen_sel = older ? rd_seen : min_seen;
    if (found) begin
      new_slot = chk_idx;
    end else if (used_full) begin
      new_slot = min_sel;
    end else begin
      new_slot = used[IDX_W-1:0];
    end
    issue    = (state == ST_SCAN) && !decide && (issue_cnt < used);
    mem_we   = decide && is_adv;
    load_out = (state == ST_FINISH) && (!out_valid || pop);
    q_pop    = (state == ST_IDLE) && !q_empty;
    empty    = !out_valid;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (!q_empty) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (decide) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (load_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mac_mem[new_slot]  <= cur.mac;
      seen_mem[new_slot] <= cur.now;
      conf_mem[new_slot] <= cur.score;
    end
    rd_mac  <= mac_mem[issue_cnt[IDX_W-1:0]];
    rd_seen <= seen_mem[issue_cnt[IDX_W-1:0]];
    rd_conf <= conf_mem[issue_cnt[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      issue_cnt <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        issue_cnt <= '0;
        chk_valid <= 1'b0;
      end else begin
        chk_valid <= issue;
        if (issue) issue_cnt <= issue_cnt + 1'b1;
      end
      if (mem_we && !found && !used_full) begin
        used <= used + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_word;
    end
    if (issue) begin
      chk_idx <= issue_cnt[IDX_W-1:0];
    end
    if (state == ST_SCAN && chk_valid) begin
      min_seen <= min_seen_sel;
      min_idx  <= min_sel;
    end
    if (decide) begin
      res_slot  <= new_slot;
      res_new   <= !found;
      res_alert <= is_adv ? ((cur.verdict == VERDICT_LIKELY) || !found) : found;
    end
    if (load_out) begin
      kind       <= cur.kind;
      slot_index <= is_adv ? res_slot : '0;
      is_new     <= is_adv ? res_new : 1'b0;
      confidence <= is_adv ? cur.score : '0;
      method     <= is_adv ? cur.method : METHOD_NONE;
      verdict    <= is_adv ? cur.verdict : VERDICT_CANDIDATE;
      alert      <= res_alert;
    end
  end

endmodule

### hw/rtl/beacon_score_device_table.sv
// Top level of the beacon score device table: config registers, front end, queue, table engine.
//
//   channel   handshake               words
//   input     push / full             advertisement report or heartbeat tick
//   result    empty / pop             one result word per kept item
//   config    write_enable (no wait)  write_index selects, write_data carries value
//
// The front end takes one word per cycle while full is low; dropped words and heartbeats
// not yet due end there. A kept advertisement is handled in the table engine by one table
// read per cycle over the used entries, up to a matching address, then allocate/update.
// A due heartbeat scans the same way and stops at the first likely, recent entry.
// Synchronous reset; the table needs no clearing pass (only used entries are read).
// A two-word queue and the result register let input and output stall independently.
`timescale 1ns / 1ps
module beacon_score_device_table import bsdt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  logic              operation,
  input  logic [47:0]       mac_address,
  input  logic signed [7:0] signal_strength,
  input  logic              has_mfr_data,
  input  logic [15:0]       mfr_id,
  input  logic              name_match,
  input  logic              uuid_match,
  input  logic [31:0]       now_ms,
  output logic              empty,
  input  logic              pop,
  output logic              kind,
  output logic [IDX_W-1:0]  slot_index,
  output logic              is_new,
  output logic [6:0]        confidence,
  output logic [1:0]        method,
  output logic [1:0]        verdict,
  output logic              alert,
  input  logic              write_enable,
  input  logic [2:0]        write_index,
  input  logic [31:0]       write_data
);

  cfg_t cfg;
  logic q_push;
  job_t q_wdata;
  logic q_pop;
  logic q_empty;
  job_t q_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mfr_weight          <= RST_MFR_WEIGHT;
      cfg.name_weight         <= RST_NAME_WEIGHT;
      cfg.uuid_weight         <= RST_UUID_WEIGHT;
      cfg.proximity_bonus     <= RST_PROX_BONUS;
      cfg.likely_level        <= RST_LIKELY;
      cfg.possible_level      <= RST_POSSIBLE;
      cfg.rssi_floor          <= RST_RSSI_FLOOR;
      cfg.heartbeat_period_ms <= RST_HB_PERIOD;
    end else if (write_enable) begin
      case (reg_index_e'(write_index))
        REG_MFR_WEIGHT:  cfg.mfr_weight          <= write_data[6:0];
        REG_NAME_WEIGHT: cfg.name_weight         <= write_data[6:0];
        REG_UUID_WEIGHT: cfg.uuid_weight         <= write_data[6:0];
        REG_PROX_BONUS:  cfg.proximity_bonus     <= write_data[6:0];
        REG_LIKELY:      cfg.likely_level        <= write_data[6:0];
        REG_POSSIBLE:    cfg.possible_level      <= write_data[6:0];
        REG_RSSI_FLOOR:  cfg.rssi_floor          <= write_data[7:0];
        REG_HB_PERIOD:   cfg.heartbeat_period_ms <= write_data;
        default: ;
      endcase
    end
  end

  bsdt_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .push            (push),
    .full            (full),
    .operation       (operation),
    .mac_address     (mac_address),
    .signal_strength (signal_strength),
    .has_mfr_data    (has_mfr_data),
    .mfr_id          (mfr_id),
    .name_match      (name_match),
    .uuid_match      (uuid_match),
    .now_ms          (now_ms),
    .q_push          (q_push),
    .q_word          (q_wdata)
  );

  bsdt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_wdata (q_wdata),
    .q_full  (full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_rdata (q_rdata)
  );

  bsdt_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .q_empty    (q_empty),
    .q_word     (q_rdata),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .kind       (kind),
    .slot_index (slot_index),
    .is_new     (is_new),
    .confidence (confidence),
    .method     (method),
    .verdict    (verdict),
    .alert      (alert)
  );

endmodule
